### hdl/bba_pkg.sv
// constants, types and codes shared by the block bitmap allocator files
package bba_pkg;

    localparam int MAP_BITS  = 4096;
    localparam int WORD_BITS = 32;
    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;

    localparam int WADDR_W = $clog2(MAP_WORDS);
    localparam int WOFF_W  = $clog2(WORD_BITS);
    localparam int BIT_W   = WADDR_W + WOFF_W;
    localparam int LIM_W   = $clog2(MAP_BITS + 1);

    localparam int BLK_W    = 16;
    localparam int ZONE_W   = 13;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DATA_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_COUNT = 2'd1;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BELOW = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREE  = 3'd4;

    localparam logic [BLK_W-1:0]  DATA_BASE_RST  = 16'd1;
    localparam logic [ZONE_W-1:0] ZONE_COUNT_RST = 13'd4096;

    typedef struct packed {
        logic             func;
        logic [BLK_W-1:0] block_in;
    } req_t;

    typedef struct packed {
        logic [BLK_W-1:0]    block_out;
        logic [STATUS_W-1:0] status;
    } rsp_t;

endpackage

### hdl/bba_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/block_bitmap_allocator_top.sv
// block bitmap allocator: first-fit allocate and checked free over a ram bitmap
//
//  channel | direction | handshake          | word
//  req     | in        | req_valid/req_stall | func, block_in
//  rsp     | out       | rsp_valid/rsp_stall | block_out, status
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// allocate: accept, then scan the bitmap one word at a time (up to 128 words, one ram read each),
// then hand off; an empty zone goes straight from accept to hand off
// free: accept with read, check and write back, hand off; bounds errors go straight to hand off
// reset clears per-word valid bits, so a word never written reads as its reset value
// a finished word waits in the output register while the next request is taken
// hand off waits while the output register holds a stalled word
module block_bitmap_allocator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  bba_pkg::req_t                     req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output bba_pkg::rsp_t                     rsp,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import bba_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FCHK,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [BLK_W-1:0]     base_reg;
    logic [ZONE_W-1:0]    zone_reg;
    logic [WADDR_W-1:0]   rd_addr_reg;
    logic [WOFF_W-1:0]    off_reg, off_next;
    logic                 rvalid_reg;
    logic [MAP_WORDS-1:0] valid_reg;
    rsp_t                 res_reg, res_next;
    rsp_t                 rsp_reg;
    logic                 rsp_valid_reg;

    logic                 ram_we;
    logic [WADDR_W-1:0]   ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WADDR_W-1:0]   ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [LIM_W-1:0]     lim;
    logic [LIM_W-1:0]     lim_m1;
    logic [WADDR_W-1:0]   last_word;
    logic [WOFF_W-1:0]    last_off;
    logic [WORD_BITS-1:0] word_cur;
    logic [WORD_BITS-1:0] avail;
    logic                 found;
    logic [WOFF_W-1:0]    found_off;
    logic [BIT_W:0]       free_bit;
    logic                 rsp_load;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign lim = (32'(zone_reg) < MAP_BITS) ? LIM_W'(zone_reg) : LIM_W'(MAP_BITS);
    assign lim_m1    = lim - LIM_W'(1);
    assign last_word = lim_m1[WOFF_W +: WADDR_W];
    assign last_off  = lim_m1[WOFF_W-1:0];

    // a word never written since reset reads as its reset value
    assign word_cur = rvalid_reg ? ram_rdata :
                      ((rd_addr_reg == '0) ? WORD_BITS'(1) : '0);

    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            avail[j] = ~word_cur[j] &
                       ((rd_addr_reg != last_word) || (WOFF_W'(j) <= last_off));
        end
    end

    // lowest clear bit in the word that lies inside the zone
    always_comb
    begin
        found     = 1'b0;
        found_off = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (avail[j])
            begin
                found     = 1'b1;
                found_off = WOFF_W'(j);
            end
        end
    end

    assign free_bit = (BIT_W+1)'(req.block_in) - (BIT_W+1)'(base_reg) + (BIT_W+1)'(1);
    assign rsp_load = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        off_next   = off_reg;
        ram_we     = 1'b0;
        ram_waddr  = rd_addr_reg;
        ram_wdata  = word_cur;
        ram_raddr  = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_next.block_out = '0;
                    res_next.status    = ST_OK;
                    if (req.func == FUNC_ALLOC)
                    begin
                        if (lim == '0)
                        begin
                            res_next.status = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (req.block_in < base_reg)
                    begin
                        res_next.status = ST_BELOW;
                        state_next      = S_DONE;
                    end
                    else if (req.block_in >= BLK_W'(zone_reg))
                    begin
                        res_next.status = ST_RANGE;
                        state_next      = S_DONE;
                    end
                    else if (free_bit >= (BIT_W+1)'(lim))
                    begin
                        res_next.status = ST_RANGE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        ram_raddr  = free_bit[WOFF_W +: WADDR_W];
                        off_next   = free_bit[WOFF_W-1:0];
                        state_next = S_FCHK;
                    end
                end
            end
            S_SCAN:
            begin
                ram_raddr = rd_addr_reg + WADDR_W'(1);
                if (found)
                begin
                    ram_we             = 1'b1;
                    ram_wdata          = word_cur | (WORD_BITS'(1) << found_off);
                    res_next.block_out = base_reg + BLK_W'({rd_addr_reg, found_off})
                                         - BLK_W'(1);
                    res_next.status    = ST_OK;
                    state_next         = S_DONE;
                end
                else if (rd_addr_reg == last_word)
                begin
                    res_next.status = ST_FULL;
                    state_next      = S_DONE;
                end
            end
            S_FCHK:
            begin
                if (!word_cur[off_reg])
                begin
                    res_next.status = ST_FREE;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = word_cur & ~(WORD_BITS'(1) << off_reg);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= DATA_BASE_RST;
            zone_reg      <= ZONE_COUNT_RST;
            rd_addr_reg   <= '0;
            off_reg       <= '0;
            rvalid_reg    <= 1'b0;
            valid_reg     <= '0;
            res_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_addr_reg <= ram_raddr;
            off_reg     <= off_next;
            res_reg     <= res_next;
            rvalid_reg  <= valid_reg[ram_raddr];
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_DATA_BASE)
                begin
                    base_reg <= cfg_data[BLK_W-1:0];
                end
                else if (cfg_index == REG_ZONE_COUNT)
                begin
                    zone_reg <= cfg_data[ZONE_W-1:0];
                end
            end
            if (state_reg == S_DONE && rsp_load)
            begin
                rsp_reg       <= res_reg;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

endmodule

### hdl/bba_checker.sv
// port-level checks for the block bitmap allocator and their bind
module bba_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_stall,
    input logic                           rsp_valid,
    input logic                           rsp_stall,
    input bba_pkg::rsp_t                  rsp
);

    import bba_pkg::*;

    // a stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response word changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_FULL ||
                       rsp.status == ST_BELOW || rsp.status == ST_RANGE ||
                       rsp.status == ST_FREE))
        else $error("undefined status code");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.block_out == '0)
        else $error("block number on a failed request");

    // no response can appear the cycle after a request is taken
    a_no_early_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
        else $error("response without processing time");

endmodule

bind block_bitmap_allocator_top bba_checker u_bba_checker (.*);
